// ----- rtl/core/dpt_pkg.sv -----
// Shared types and constants of the demand paging translator.
package dpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    OP_TRANSLATE = 1'b0,
    OP_WRITE     = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP,
    BK_COPY,
    BK_COMMIT,
    BK_READ
  } bk_state_e;

endpackage

// ----- rtl/core/dpt_front.sv -----
// Front end: accepts items and splits the address into page and offset.
module dpt_front #(
  parameter int NUM_PAGES  = 256,
  parameter int PAGE_BYTES = 256,
  localparam int PW = $clog2(NUM_PAGES),
  localparam int OW = $clog2(PAGE_BYTES),
  localparam int EW = 1 + dpt_pkg::DATA_W + PW + OW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dpt_pkg::op_e                in_op_i,
  input  logic [dpt_pkg::ADDR_W-1:0]  in_addr_i,
  input  logic [dpt_pkg::DATA_W-1:0]  in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [EW-1:0]               out_entry_o
);

  localparam int AW = dpt_pkg::ADDR_W;
  localparam int DW = dpt_pkg::DATA_W;

  // Exact division by a constant: floor(n * M / 2^S) with M = ceil(2^S / d).
  localparam int S1  = AW + OW;
  localparam int M1W = AW + 1;
  localparam longint unsigned M1 =
    ((64'd1 << S1) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [M1W-1:0] M1_C = M1W'(M1);
  localparam int P1W = AW + M1W;

  localparam int QMAX = ((1 << AW) - 1) / PAGE_BYTES;
  localparam int QW   = $clog2(QMAX + 1);
  localparam int S2   = QW + PW;
  localparam int M2W  = QW + 1;
  localparam longint unsigned M2 =
    ((64'd1 << S2) + 64'(NUM_PAGES) - 64'd1) / 64'(NUM_PAGES);
  localparam logic [M2W-1:0] M2_C = M2W'(M2);
  localparam int P2W = QW + M2W;

  logic           en;
  logic           v1_q, v2_q;
  dpt_pkg::op_e   op1_q, op2_q;
  logic [AW-1:0]  addr1_q;
  logic [DW-1:0]  data1_q, data2_q;
  logic [P1W-1:0] prod1_q;
  logic [P2W-1:0] prod2_q;
  logic [QW-1:0]  quo1;
  logic [QW-1:0]  quo2_q;
  logic [QW-1:0]  quo_hi;
  logic [OW-1:0]  off2_q;
  logic [PW-1:0]  page;

  // The whole pipeline advances together whenever its last stage can move on.
  assign en         = !v2_q || out_ready_i;
  assign in_ready_o = en;

  assign quo1   = QW'(prod1_q >> S1);
  assign quo_hi = QW'(prod2_q >> S2);
  assign page   = PW'(quo2_q - QW'(quo_hi * NUM_PAGES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q   <= in_op_i;
      addr1_q <= in_addr_i;
      data1_q <= in_data_i;
      prod1_q <= P1W'(in_addr_i) * P1W'(M1_C);
      op2_q   <= op1_q;
      data2_q <= data1_q;
      quo2_q  <= quo1;
      off2_q  <= OW'(addr1_q - AW'(quo1 * PAGE_BYTES));
      prod2_q <= P2W'(quo1) * P2W'(M2_C);
    end
  end

  assign out_valid_o = v2_q;
  assign out_entry_o = {op2_q, data2_q, page, off2_q};

endmodule

// ----- rtl/core/dpt_queue.sv -----
// Small FIFO that decouples the front end from the back end.
module dpt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_i
);

  localparam int DEPTH = dpt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/dpt_back.sv -----
// Back end: page table, backing store writes, page copy from the backing store, frame reads.
module dpt_back #(
  parameter int NUM_PAGES  = 256,
  parameter int PAGE_BYTES = 256,
  localparam int PW = $clog2(NUM_PAGES),
  localparam int OW = $clog2(PAGE_BYTES),
  localparam int EW = 1 + dpt_pkg::DATA_W + PW + OW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  logic [EW-1:0]                     q_entry_i,
  output logic                              q_pop_o,
  output logic                              init_busy_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [dpt_pkg::ADDR_W-1:0]        m_phys_o,
  output logic signed [dpt_pkg::DATA_W-1:0] m_value_o,
  output logic                              m_fault_o
);

  localparam int AW    = dpt_pkg::ADDR_W;
  localparam int DW    = dpt_pkg::DATA_W;
  localparam int STORE = NUM_PAGES * PAGE_BYTES;
  localparam int SW    = $clog2(STORE);
  localparam int CW    = $clog2(NUM_PAGES + 1);
  localparam int CPW   = $clog2(PAGE_BYTES + 1);
  localparam int TW    = PW + 1;

  function automatic logic [SW-1:0] mem_addr(logic [PW-1:0] pg, logic [OW-1:0] off);
    mem_addr = SW'(pg * PAGE_BYTES) + SW'(off);
  endfunction

  dpt_pkg::bk_state_e state_q, state_d;

  dpt_pkg::op_e   head_op;
  logic [DW-1:0]  head_data;
  logic [PW-1:0]  head_page;
  logic [OW-1:0]  head_off;

  logic [PW-1:0]  clr_q, clr_d;
  logic [CW-1:0]  free_q, free_d;
  logic [CPW-1:0] cp_q, cp_d;
  logic           wv_q, wv_d;
  logic [OW-1:0]  widx_q, widx_d;
  logic [PW-1:0]  page_q, page_d;
  logic [OW-1:0]  off_q, off_d;
  logic [PW-1:0]  frame_q, frame_d;
  logic           fault_q, fault_d;
  logic [SW-1:0]  src_q, src_d;
  logic [SW-1:0]  dst_q, dst_d;

  logic           out_v_q, out_v_d;
  logic [AW-1:0]  phys_q, phys_d;
  logic [DW-1:0]  value_q, value_d;
  logic           ofault_q, ofault_d;

  logic [TW-1:0]  pt_mem [NUM_PAGES];
  logic [DW-1:0]  fs_mem [STORE];
  logic [DW-1:0]  bs_mem [STORE];

  logic           pt_we, pt_re;
  logic [PW-1:0]  pt_waddr, pt_raddr;
  logic [TW-1:0]  pt_wdata, pt_rdata_q;
  logic           fs_we, fs_re;
  logic [SW-1:0]  fs_waddr, fs_raddr;
  logic [DW-1:0]  fs_wdata, fs_rdata_q;
  logic           bs_we, bs_re;
  logic [SW-1:0]  bs_waddr, bs_raddr;
  logic [DW-1:0]  bs_wdata, bs_rdata_q;

  assign head_op   = dpt_pkg::op_e'(q_entry_i[EW-1]);
  assign head_data = q_entry_i[OW+PW +: DW];
  assign head_page = q_entry_i[OW +: PW];
  assign head_off  = q_entry_i[OW-1:0];

  assign fs_wdata = bs_rdata_q;
  assign bs_wdata = head_data;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    free_d   = free_q;
    cp_d     = cp_q;
    wv_d     = 1'b0;
    widx_d   = widx_q;
    page_d   = page_q;
    off_d    = off_q;
    frame_d  = frame_q;
    fault_d  = fault_q;
    src_d    = src_q;
    dst_d    = dst_q;
    out_v_d  = out_v_q && !m_ready_i;
    phys_d   = phys_q;
    value_d  = value_q;
    ofault_d = ofault_q;

    q_pop_o  = 1'b0;
    pt_we    = 1'b0;
    pt_waddr = page_q;
    pt_wdata = {1'b1, frame_q};
    pt_re    = 1'b0;
    pt_raddr = head_page;
    fs_we    = 1'b0;
    fs_waddr = dst_q + SW'(widx_q);
    fs_re    = 1'b0;
    fs_raddr = mem_addr(frame_q, off_q);
    bs_we    = 1'b0;
    bs_waddr = mem_addr(head_page, head_off);
    bs_re    = 1'b0;
    bs_raddr = src_q + SW'(cp_q[OW-1:0]);

    case (state_q)
      dpt_pkg::BK_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_q;
        pt_wdata = '0;
        clr_d    = clr_q + PW'(1);
        if (clr_q == PW'(NUM_PAGES - 1)) begin
          state_d = dpt_pkg::BK_IDLE;
        end
      end
      dpt_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (head_op == dpt_pkg::OP_WRITE) begin
            bs_we = 1'b1;
          end else begin
            pt_re   = 1'b1;
            page_d  = head_page;
            off_d   = head_off;
            state_d = dpt_pkg::BK_LOOKUP;
          end
        end
      end
      dpt_pkg::BK_LOOKUP: begin
        if (pt_rdata_q[PW]) begin
          frame_d  = pt_rdata_q[PW-1:0];
          fault_d  = 1'b0;
          fs_re    = 1'b1;
          fs_raddr = mem_addr(pt_rdata_q[PW-1:0], off_q);
          state_d  = dpt_pkg::BK_READ;
        end else begin
          // Frames are handed out in order, so the next one is the fill count.
          frame_d = PW'(free_q);
          fault_d = 1'b1;
          src_d   = mem_addr(page_q, '0);
          dst_d   = mem_addr(PW'(free_q), '0);
          cp_d    = '0;
          state_d = dpt_pkg::BK_COPY;
        end
      end
      dpt_pkg::BK_COPY: begin
        // Reads run one byte ahead of the writes into the frame.
        if (cp_q != CPW'(PAGE_BYTES)) begin
          bs_re = 1'b1;
          cp_d  = cp_q + CPW'(1);
        end
        wv_d   = bs_re;
        widx_d = cp_q[OW-1:0];
        if (wv_q) begin
          fs_we = 1'b1;
          if (cp_q == CPW'(PAGE_BYTES)) begin
            state_d = dpt_pkg::BK_COMMIT;
          end
        end
      end
      dpt_pkg::BK_COMMIT: begin
        pt_we = 1'b1;
        if (free_q != CW'(NUM_PAGES)) begin
          free_d = free_q + CW'(1);
        end
        fs_re   = 1'b1;
        state_d = dpt_pkg::BK_READ;
      end
      dpt_pkg::BK_READ: begin
        if (!out_v_q || m_ready_i) begin
          out_v_d  = 1'b1;
          phys_d   = AW'(frame_q * PAGE_BYTES + off_q);
          value_d  = fs_rdata_q;
          ofault_d = fault_q;
          state_d  = dpt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = dpt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpt_pkg::BK_CLEAR;
      clr_q   <= '0;
      free_q  <= '0;
      cp_q    <= '0;
      wv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      cp_q    <= cp_d;
      wv_q    <= wv_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q   <= widx_d;
    page_q   <= page_d;
    off_q    <= off_d;
    frame_q  <= frame_d;
    fault_q  <= fault_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    phys_q   <= phys_d;
    value_q  <= value_d;
    ofault_q <= ofault_d;
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rdata_q <= pt_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rdata_q <= fs_mem[fs_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bs_we) begin
      bs_mem[bs_waddr] <= bs_wdata;
    end
    if (bs_re) begin
      bs_rdata_q <= bs_mem[bs_raddr];
    end
  end

  assign init_busy_o = (state_q == dpt_pkg::BK_CLEAR);
  assign m_valid_o   = out_v_q;
  assign m_phys_o    = phys_q;
  assign m_value_o   = signed'(value_q);
  assign m_fault_o   = ofault_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CW'(NUM_PAGES))
    else $error("frame fill count exceeds the number of pages");

  a_free_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpt_pkg::BK_LOOKUP && !pt_rdata_q[PW]) |-> (free_q < CW'(NUM_PAGES)))
    else $error("page fault with no free frame left");

  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpt_pkg::BK_COMMIT) |=> (free_q == $past(free_q) + CW'(1)))
    else $error("page load did not consume exactly one frame");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpt_pkg::BK_READ && (!out_v_q || m_ready_i))
      |=> (out_v_q && state_q == dpt_pkg::BK_IDLE))
    else $error("finished translation did not reach the output register");

endmodule

// ----- rtl/core/demand_paging_translator_top.sv -----
// Top level of the demand paging address translator.
//
// Items enter on the s_axis channel. tuser selects the operation: translate a
// virtual address, or write one byte of the backing store. A write produces no
// result; a translate produces one result on the m_axis channel with the
// physical address, the byte stored there and a page fault flag in tuser.
// Backing store bytes of a page must be written before that page is translated.
// An accepted item passes through the front end's pipeline, then waits in a
// four-entry queue for the back end. A translate that hits goes through the
// back end's idle, lookup and read states into the output register; a write
// is done in the idle state. A fault first copies the page one byte per cycle
// through the single backing store read port and then commits the table entry.
// After reset the page table is cleared one entry per cycle while s_axis_tready
// stays low. When the receiver stalls, the result waits in the output register,
// the back end holds, the queue fills and then tready drops.
module demand_paging_translator_top #(
  parameter int NUM_PAGES  = 256,
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // address [15:0], data_byte [23:16]
  input  logic [0:0]  s_axis_tuser,   // operation [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // phys_addr [15:0], read_value [23:16]
  output logic [0:0]  m_axis_tuser    // page_fault [0]
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int EW = 1 + dpt_pkg::DATA_W + PW + OW;

  logic                              init_busy;
  logic                              front_ready;
  logic                              front_valid;
  logic                              q_push_ready;
  logic                              q_valid;
  logic                              q_pop;
  logic [EW-1:0]                     front_entry;
  logic [EW-1:0]                     q_entry;
  logic [dpt_pkg::ADDR_W-1:0]        res_phys;
  logic signed [dpt_pkg::DATA_W-1:0] res_value;
  logic                              res_fault;

  assign s_axis_tready = front_ready && !init_busy;

  dpt_front #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && !init_busy),
    .in_ready_o  (front_ready),
    .in_op_i     (dpt_pkg::op_e'(s_axis_tuser[0])),
    .in_addr_i   (s_axis_tdata[15:0]),
    .in_data_i   (s_axis_tdata[23:16]),
    .out_valid_o (front_valid),
    .out_ready_i (q_push_ready),
    .out_entry_o (front_entry)
  );

  dpt_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_valid),
    .push_data_i  (front_entry),
    .push_ready_o (q_push_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_entry),
    .pop_i        (q_pop)
  );

  dpt_back #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_phys_o    (res_phys),
    .m_value_o   (res_value),
    .m_fault_o   (res_fault)
  );

  assign m_axis_tdata = {res_value, res_phys};
  assign m_axis_tuser = res_fault;

endmodule

// ----- sim/page_translation_checker.sv -----
// Watches both channels of the translator, predicts each translation and compares results.
`timescale 1ns / 1ps

module page_translation_checker #(
  parameter int NUM_PAGES  = 256,
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // address [15:0], data_byte [23:16]
  input  logic [0:0]  s_tuser_i,   // operation [0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,   // phys_addr [15:0], read_value [23:16]
  input  logic [0:0]  m_tuser_i,   // page_fault [0]
  output int          mismatch_count_o,
  output int          pending_o,
  output int          results_o,
  output int          faults_o
);

  localparam int STORE_BYTES = NUM_PAGES * PAGE_BYTES;

  typedef struct packed {
    logic [dpt_pkg::ADDR_W-1:0]        paddr;
    logic signed [dpt_pkg::DATA_W-1:0] value;
    logic                              fault;
  } xlat_t;

  // Unwritten bytes and table entries start at zero.
  bit [dpt_pkg::DATA_W-1:0] backing_mem [STORE_BYTES];
  bit [dpt_pkg::DATA_W-1:0] frame_mem [STORE_BYTES];
  bit                       page_valid [NUM_PAGES];
  int                       page_frame [NUM_PAGES];
  int                       frames_used;
  xlat_t                    pending_xlat_q [$];
  xlat_t                    want;
  int                       mismatches;
  int                       results;
  int                       faults;

  function automatic xlat_t walk_page_table(input logic [dpt_pkg::ADDR_W-1:0] vaddr);
    int    page;
    int    offset;
    int    frame;
    int    phys;
    int    i;
    xlat_t r;
    page   = (int'(vaddr) / PAGE_BYTES) % NUM_PAGES;
    offset = int'(vaddr) % PAGE_BYTES;
    r.fault = !page_valid[page];
    if (!page_valid[page]) begin
      // A miss copies the whole page into the next frame in order.
      frame = frames_used % NUM_PAGES;
      for (i = 0; i < PAGE_BYTES; i++) begin
        frame_mem[(frame * PAGE_BYTES + i) % STORE_BYTES] =
          backing_mem[(page * PAGE_BYTES + i) % STORE_BYTES];
      end
      page_frame[page] = frame;
      page_valid[page] = 1'b1;
      if (frames_used < NUM_PAGES) frames_used++;
    end else begin
      frame = page_frame[page] % NUM_PAGES;
    end
    phys    = frame * PAGE_BYTES + offset;
    r.paddr = phys[dpt_pkg::ADDR_W-1:0];
    r.value = frame_mem[phys % STORE_BYTES];
    return r;
  endfunction

  initial begin
    frames_used = 0;
    mismatches  = 0;
    results     = 0;
    faults      = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Results are checked before new inputs are predicted; no accepted item can
      // leave the block in the same cycle.
      if (m_tvalid_i && m_tready_i) begin
        results++;
        if (m_tuser_i[0]) faults++;
        if (pending_xlat_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, actual paddr %h value %h fault %b",
                   $time, m_tdata_i[15:0], m_tdata_i[23:16], m_tuser_i[0]);
        end else begin
          want = pending_xlat_q.pop_front();
          if (m_tdata_i[15:0] !== want.paddr) begin
            mismatches++;
            $display("%0t: phys_addr expected %h actual %h",
                     $time, want.paddr, m_tdata_i[15:0]);
          end
          if (m_tdata_i[23:16] !== want.value) begin
            mismatches++;
            $display("%0t: read_value expected %0d actual %0d",
                     $time, want.value, $signed(m_tdata_i[23:16]));
          end
          if (m_tuser_i[0] !== want.fault) begin
            mismatches++;
            $display("%0t: page_fault expected %b actual %b",
                     $time, want.fault, m_tuser_i[0]);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == dpt_pkg::OP_WRITE) begin
          backing_mem[int'(s_tdata_i[15:0]) % STORE_BYTES] = s_tdata_i[23:16];
        end else begin
          pending_xlat_q.push_back(walk_page_table(s_tdata_i[15:0]));
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= pending_xlat_q.size();
    results_o        <= results;
    faults_o         <= faults;
  end

endmodule

// ----- sim/demand_paging_translator_top_tb.sv -----
// Stimulus, handshake pressure and verdict for the demand paging translator.
`timescale 1ns / 1ps

module demand_paging_translator_top_tb;

  localparam int NUM_PAGES      = 256;
  localparam int PAGE_BYTES     = 256;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // address [15:0], data_byte [23:16]
  logic [0:0]  s_axis_tuser;   // operation [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // phys_addr [15:0], read_value [23:16]
  logic [0:0]  m_axis_tuser;   // page_fault [0]

  int mismatch_count;
  int pending;
  int results;
  int faults;

  int send_idle_pct;
  int recv_idle_pct;
  int writes_sent;
  int translates_sent;
  int quiet_cycles;

  // Pages whose backing bytes are all written and may be translated.
  logic [7:0] filled_q [$];
  bit         page_filled [NUM_PAGES];

  demand_paging_translator_top #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  page_translation_checker #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .results_o        (results),
    .faults_o         (faults)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, pending);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input dpt_pkg::op_e op, input logic [15:0] addr,
                           input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == dpt_pkg::OP_WRITE) writes_sent++;
    else translates_sent++;
  endtask

  // Either a translation of a filled page or a write anywhere. A stray write
  // into an unfilled page is harmless, since a later fill covers every byte.
  task automatic random_extra();
    logic [7:0] page;
    if ($urandom_range(3) != 0) begin
      page = filled_q[$urandom_range(filled_q.size() - 1)];
      send_item(dpt_pkg::OP_TRANSLATE, {page, 8'($urandom)}, 8'($urandom));
    end else begin
      send_item(dpt_pkg::OP_WRITE, 16'($urandom), 8'($urandom));
    end
  endtask

  // Writes every backing byte of a page once, in shuffled order, with random extra items between the writes.
  task automatic fill_page(input logic [7:0] page, input int extra_pct);
    logic [7:0] order [256];
    logic [7:0] tmp;
    int         i;
    int         j;
    for (i = 0; i < 256; i++) order[i] = 8'(i);
    for (i = 255; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < 256; i++) begin
      send_item(dpt_pkg::OP_WRITE, {page, order[i]}, 8'($urandom));
      if (filled_q.size() != 0 && $urandom_range(99) < extra_pct) random_extra();
    end
  endtask

  initial begin
    logic [7:0] page;
    int         phase;
    int         k;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = dpt_pkg::OP_TRANSLATE;
    m_axis_tready   = 1'b0;
    send_idle_pct   = 6;
    recv_idle_pct   = 61;
    writes_sent     = 0;
    translates_sent = 0;
    quiet_cycles    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: page zero with the byte extremes at known offsets.
    fill_page(8'h00, 0);
    send_item(dpt_pkg::OP_WRITE, 16'h0000, 8'h80);
    send_item(dpt_pkg::OP_WRITE, 16'h0001, 8'hFF);
    send_item(dpt_pkg::OP_WRITE, 16'h0002, 8'h00);
    send_item(dpt_pkg::OP_WRITE, 16'h00FF, 8'h7F);
    filled_q.push_back(8'h00);
    page_filled[0] = 1'b1;
    send_item(dpt_pkg::OP_TRANSLATE, 16'h0000, 8'hFF);
    send_item(dpt_pkg::OP_TRANSLATE, 16'h00FF, 8'h00);
    send_item(dpt_pkg::OP_TRANSLATE, 16'h0001, 8'h5A);
    send_item(dpt_pkg::OP_TRANSLATE, 16'h0002, 8'hA5);
    // A backing write after the page is resident must not change the frame.
    send_item(dpt_pkg::OP_WRITE, 16'h0000, 8'h55);
    send_item(dpt_pkg::OP_TRANSLATE, 16'h0000, 8'h00);
    send_item(dpt_pkg::OP_WRITE, 16'hFFFF, 8'h80);
    send_item(dpt_pkg::OP_TRANSLATE, 16'h0080, 8'hFF);

    // Random: one new page per pressure mix, the top page first.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 61;
          page          = 8'hFF;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 6;
          do page = 8'($urandom_range(1, 254)); while (page_filled[page]);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          do page = 8'($urandom_range(1, 254)); while (page_filled[page]);
        end
      endcase
      fill_page(page, 15);
      filled_q.push_back(page);
      page_filled[page] = 1'b1;
      send_item(dpt_pkg::OP_TRANSLATE, {page, (page == 8'hFF) ? 8'hFF : 8'($urandom)},
                8'($urandom));
      for (k = 0; k < 65; k++) random_extra();
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d backing writes and %0d translations; checked %0d results, %0d faults.",
             writes_sent, translates_sent, results, faults);
    $display("Covered pages 00 and FF plus two random pages under three stall mixes.");
    if (mismatch_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dpt_pkg.sv
rtl/core/dpt_front.sv
rtl/core/dpt_queue.sv
rtl/core/dpt_back.sv
rtl/core/demand_paging_translator_top.sv
sim/page_translation_checker.sv
sim/demand_paging_translator_top_tb.sv
